FILE: rtl/dawc_pkg.sv
// Shared types and constants for the daily alarm window controller.
package dawc_pkg;

    localparam int NUM_ALARMS      = 4;
    localparam int MINUTES_PER_DAY = 1440;
    localparam int MASK_W          = 4;
    localparam int MIN_W           = 11;
    localparam int CFG_IDX_W       = 4;

    // Register indexes of the configuration port.
    localparam int REG_START_BASE    = 0;
    localparam int REG_DURATION_BASE = 4;

    typedef logic [MIN_W-1:0] minute_t;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_SYNC   = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_STOP   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] start_mask;
        logic              stop_event;
        logic [MASK_W-1:0] ringback_mask;
        logic              ringing;
    } out_item_t;

    typedef struct packed {
        minute_t [MASK_W-1:0] start;
        minute_t [MASK_W-1:0] duration;
    } cfg_t;

    typedef struct packed {
        logic              tick_ok;
        logic [MASK_W-1:0] fired;
        logic              covered;
    } eval_t;

endpackage

FILE: rtl/dawc_cfg_regs.sv
// Configuration register file holding the alarm start minutes and durations.
module dawc_cfg_regs import dawc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MIN_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    minute_t [MASK_W-1:0] start_reg;
    minute_t [MASK_W-1:0] duration_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= '0;
            duration_reg <= '0;
        end else if (cfg_valid) begin
            for (int k = 0; k < MASK_W; k++) begin
                if (cfg_index == CFG_IDX_W'(REG_START_BASE + k)) begin
                    start_reg[k] <= cfg_data;
                end
                if (cfg_index == CFG_IDX_W'(REG_DURATION_BASE + k)) begin
                    duration_reg[k] <= cfg_data;
                end
            end
        end
    end

    assign cfg.start    = start_reg;
    assign cfg.duration = duration_reg;

endmodule

FILE: rtl/dawc_alarm_eval.sv
// Per-alarm start match and window coverage for one tick.
module dawc_alarm_eval import dawc_pkg::*; (
    input  in_item_t item,
    input  cfg_t     cfg,
    output eval_t    eval
);

    localparam minute_t DAY = MIN_W'(MINUTES_PER_DAY);

    minute_t           now_raw;
    minute_t           now;
    minute_t           start_mod [MASK_W];
    logic [MIN_W:0]    diff      [MASK_W];
    minute_t           offs      [MASK_W];
    logic [MASK_W-1:0] in_win;
    logic              sec_zero;
    logic              tick_ok;
    logic [MASK_W-1:0] fired;

    // hour*60 is formed as hour*64 - hour*4; the sum stays below twice a day.
    assign now_raw = {item.hour, 6'b0} - {4'b0, item.hour, 2'b0} + {5'b0, item.minute};
    assign now     = (now_raw >= DAY) ? now_raw - DAY : now_raw;
    assign sec_zero = (item.second == 6'd0);

    always_comb begin
        case (item.second) inside
            6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50, 6'd60: tick_ok = 1'b1;
            default:                                        tick_ok = 1'b0;
        endcase
    end

    always_comb begin
        fired  = '0;
        in_win = '0;
        for (int k = 0; k < MASK_W; k++) begin
            start_mod[k] = (cfg.start[k] >= DAY) ? cfg.start[k] - DAY : cfg.start[k];
            diff[k]      = {1'b0, now} - {1'b0, start_mod[k]};
            if (now < start_mod[k]) begin
                diff[k] = diff[k] + {1'b0, DAY};
            end
            offs[k] = diff[k][MIN_W-1:0];
            if (k < NUM_ALARMS) begin
                fired[k] = sec_zero && (now == start_mod[k]);
                if (cfg.duration[k] >= DAY) begin
                    in_win[k] = 1'b1;
                end else begin
                    in_win[k] = (cfg.duration[k] != '0) && (offs[k] < cfg.duration[k]);
                end
            end
        end
    end

    assign eval = '{tick_ok: tick_ok, fired: fired, covered: |in_win};

endmodule

FILE: rtl/daily_alarm_window_controller.sv
// Daily alarm window controller: input register, combinational evaluation, result register.
// An accepted input transaction is held in the input register, and its result is written to the
// result register once the result register is empty or being taken.
// Throughput: one transaction per cycle; the input register and the result register form a
// two-stage pipeline that stalls only while the result register is full and not taken.
// Reset (aresetn low, synchronous) zeroes all configuration registers and alarm state and
// empties both pipeline stages.
module daily_alarm_window_controller import dawc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MIN_W-1:0]     cfg_data
);

    cfg_t      cfg;
    eval_t     eval;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      advance;

    logic [MASK_W-1:0] triggered_reg, triggered_next;
    logic [MASK_W-1:0] ringback_reg, ringback_next;
    logic              ring_active_reg, ring_active_next;
    logic              cancel_pending_reg, cancel_pending_next;
    logic [MASK_W-1:0] fired;
    logic              stopped;

    dawc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dawc_alarm_eval u_alarm_eval (
        .item (in_reg),
        .cfg  (cfg),
        .eval (eval)
    );

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_comb begin
        triggered_next      = triggered_reg;
        ringback_next       = ringback_reg;
        ring_active_next    = ring_active_reg;
        cancel_pending_next = cancel_pending_reg;
        fired               = '0;
        stopped             = 1'b0;
        case (in_reg.mode)
            MODE_TICK: begin
                if (eval.tick_ok) begin
                    fired          = eval.fired;
                    triggered_next = triggered_reg | eval.fired;
                    ringback_next  = eval.covered ? triggered_next : '0;
                    if (eval.fired != '0) begin
                        ring_active_next = 1'b1;
                    end
                end
            end
            MODE_SYNC: begin
                // A pending cancel stops at once; otherwise ringing ends once no ringback is left.
                if (ring_active_reg && (cancel_pending_reg || ringback_reg == '0)) begin
                    ring_active_next    = 1'b0;
                    cancel_pending_next = 1'b0;
                    triggered_next      = '0;
                    stopped             = 1'b1;
                end
            end
            MODE_CANCEL: begin
                cancel_pending_next = 1'b1;
            end
            default: begin
                ring_active_next    = 1'b0;
                cancel_pending_next = 1'b0;
                triggered_next      = '0;
                stopped             = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            triggered_reg      <= '0;
            ringback_reg       <= '0;
            ring_active_reg    <= 1'b0;
            cancel_pending_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg      <= 1'b1;
                triggered_reg      <= triggered_next;
                ringback_reg       <= ringback_next;
                ring_active_reg    <= ring_active_next;
                cancel_pending_reg <= cancel_pending_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg.start_mask    <= fired;
            out_reg.stop_event    <= stopped;
            out_reg.ringback_mask <= ringback_next;
            out_reg.ringing       <= ring_active_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
